// ----- rtl/hcbp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types and constants of the code bit packer.
// ----------------------------------------------------------------------------
package hcbp_pkg;

	// default sizes, overridable at the top level
	localparam int MAX_CODE_LEN_DEF = 32;
	localparam int NUM_SYMBOLS_DEF  = 256;

	// width of the code_bits field, an upper bound on the stored length
	localparam int CODE_FIELD_W = 32;

	localparam int BYTE_W = 8;

	// item function codes
	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_ENCODE = 2'd1,
		FUNC_FLUSH  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	// code table sequencer
	typedef enum logic {
		TBL_CLEAR,
		TBL_RUN
	} tbl_state_t;

endpackage

// ----- rtl/hcbp_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_table
// Code table memory: one write and one registered read per cycle, with a
// clearing sweep after reset that zeroes every entry.
// ----------------------------------------------------------------------------
module hcbp_table import hcbp_pkg::*; #(
	parameter int NUM_SYMBOLS = NUM_SYMBOLS_DEF,
	parameter int LEN_CAP     = CODE_FIELD_W,
	localparam int AW         = $clog2(NUM_SYMBOLS),
	localparam int LW         = $clog2(LEN_CAP + 1),
	localparam int EW         = LW + LEN_CAP
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [EW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [EW-1:0] rd_data,
	output logic          busy
);

	tbl_state_t state_q, state_nx;
	logic [AW-1:0] clr_q;
	logic          clr_last;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [EW-1:0] mem_wd;
	logic [EW-1:0] mem [NUM_SYMBOLS];
	logic [EW-1:0] rd_q;

	assign clr_last = (clr_q == AW'(NUM_SYMBOLS - 1));

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			TBL_CLEAR: if (clr_last) state_nx = TBL_RUN;
			TBL_RUN:   state_nx = TBL_RUN;
			default:   state_nx = TBL_CLEAR;
		endcase
	end

	// outputs: sweep writes zero entries, otherwise the load port writes
	always_comb begin
		busy   = 1'b0;
		mem_we = wr_en;
		mem_wa = wr_addr;
		mem_wd = wr_data;
		unique case (state_q)
			TBL_CLEAR: begin
				busy   = 1'b1;
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			TBL_RUN: begin
				busy = 1'b0;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TBL_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == TBL_CLEAR) clr_q <= clr_q + AW'(1);
		end
	end

	// memory array
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

// ----- rtl/hcbp_pack.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_pack
// Packing stage: merges the table entry with the pending bits into a
// left-aligned word, counts the finished bytes and updates the pending bits.
// ----------------------------------------------------------------------------
module hcbp_pack import hcbp_pkg::*; #(
	parameter int LEN_CAP    = CODE_FIELD_W,
	localparam int LW        = $clog2(LEN_CAP + 1),
	localparam int EW        = LW + LEN_CAP,
	localparam int ACC_W     = LEN_CAP + 2 * BYTE_W,
	localparam int TOT_W     = $clog2(LEN_CAP + BYTE_W),
	localparam int NB_W      = TOT_W - 3
) (
	input  logic             clk,
	input  logic             arst_n,
	// item entering the stage
	input  logic             take,
	input  logic             take_flush,
	input  logic             take_enc,
	input  logic             take_inr,
	input  logic [EW-1:0]    entry,
	output logic             ready,
	// finished bytes toward the emitter
	input  logic             emit_free,
	output logic             emit_load,
	output logic [ACC_W-1:0] emit_word,
	output logic [NB_W-1:0]  emit_nb
);

	localparam int SH_W = $clog2(ACC_W + 1);

	logic             valid_s1;
	logic             flush_s1;
	logic             enc_s1;
	logic             inr_s1;
	logic [6:0]       pend_q;
	logic [2:0]       cnt_q;

	logic [LW-1:0]      len;
	logic [LEN_CAP-1:0] bits;
	logic               enc_ok;
	logic [SH_W-1:0]    shamt;
	logic [ACC_W-1:0]   pend_word;
	logic [ACC_W-1:0]   enc_word;
	logic [TOT_W-1:0]   total;
	logic [ACC_W-1:0]   rest_word;
	logic [NB_W-1:0]    nb;
	logic [ACC_W-1:0]   word;
	logic               adv;

	assign len  = entry[EW-1 -: LW];
	assign bits = entry[LEN_CAP-1:0];
	assign enc_ok = enc_s1 && inr_s1 && (len != '0);

	// pending bits sit at the top, the code right after them
	assign pend_word = {pend_q, 1'b0, (ACC_W - BYTE_W)'(0)};
	assign shamt     = SH_W'(ACC_W) - SH_W'(cnt_q) - SH_W'(len);
	assign enc_word  = pend_word | (ACC_W'(bits) << shamt);
	assign total     = TOT_W'(cnt_q) + TOT_W'(len);
	assign rest_word = enc_word << {total[TOT_W-1:3], 3'b000};

	// byte count and output word per function
	always_comb begin
		word = pend_word;
		nb   = '0;
		if (flush_s1) begin
			nb = (cnt_q != 3'd0) ? NB_W'(1) : '0;
		end else if (enc_ok) begin
			word = enc_word;
			nb   = total[TOT_W-1:3];
		end
	end

	assign adv       = valid_s1 && ((nb == '0) || emit_free);
	assign ready     = !valid_s1 || adv;
	assign emit_load = adv && (nb != '0);
	assign emit_word = word;
	assign emit_nb   = nb;

	// stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready) begin
			valid_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take && ready) begin
			flush_s1 <= take_flush;
			enc_s1   <= take_enc;
			inr_s1   <= take_inr;
		end
	end

	// pending bits, kept left aligned with zeros below the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (adv) begin
			if (flush_s1) begin
				pend_q <= '0;
				cnt_q  <= '0;
			end else if (enc_ok) begin
				pend_q <= rest_word[ACC_W-1 -: 7];
				cnt_q  <= total[2:0];
			end
		end
	end

endmodule

// ----- rtl/hcbp_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbp_emit
// Output stage: holds one packed word and hands out its bytes, first byte
// from the top, one per accepted result item.
// ----------------------------------------------------------------------------
module hcbp_emit import hcbp_pkg::*; #(
	parameter int LEN_CAP = CODE_FIELD_W,
	localparam int ACC_W  = LEN_CAP + 2 * BYTE_W,
	localparam int TOT_W  = $clog2(LEN_CAP + BYTE_W),
	localparam int NB_W   = TOT_W - 3
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [ACC_W-1:0]  word,
	input  logic [NB_W-1:0]   nb,
	output logic              free,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last_of_run
);

	logic             valid_s2;
	logic [ACC_W-1:0] word_s2;
	logic [NB_W-1:0]  left_s2;
	logic             one_left;

	assign one_left = (left_s2 == NB_W'(1));
	assign free     = !valid_s2 || (res_ready && one_left);

	// valid and byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			left_s2  <= '0;
		end else if (load) begin
			valid_s2 <= 1'b1;
			left_s2  <= nb;
		end else if (valid_s2 && res_ready) begin
			if (one_left) valid_s2 <= 1'b0;
			left_s2 <= left_s2 - NB_W'(1);
		end
	end

	// byte shifter
	always_ff @(posedge clk) begin
		if (load) begin
			word_s2 <= word;
		end else if (valid_s2 && res_ready) begin
			word_s2 <= word_s2 << BYTE_W;
		end
	end

	assign res_valid   = valid_s2;
	assign out_byte    = word_s2[ACC_W-1 -: BYTE_W];
	assign last_of_run = one_left;

endmodule

// ----- rtl/huffman_code_bit_packer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_bit_packer
// Prefix code back end: loads a per-symbol code table, packs encoded
// symbols into bytes, first code bit in bit 7, and pads on flush.
// ----------------------------------------------------------------------------
// Usage
//   Input channel sym_valid/sym_ready carries func, symbol, code_bits and
//   code_len. A load writes one table entry, an encode appends the symbol's
//   code to the pending bits, a flush pads the pending bits with zeros.
//   Output channel res_valid/res_ready carries out_byte and last_of_run;
//   last_of_run marks the final byte caused by one input item.
//   Order: an encode or flush enters the packing stage at acceptance, an
//   encode also reading the table; the packing stage loads the output stage
//   once that stage is free, which then presents the item's first byte.
//   Throughput: one item per cycle unless the packing stage stalls; an item
//   completing k bytes holds the output stage until all k are taken, so the
//   output byte rate, at most one byte per cycle, sets the sustained rate.
//   Reset: the table is swept to zero over all NUM_SYMBOLS entries, one per
//   cycle; sym_ready stays low during the sweep. Pending bits reset empty.
//   Stall: the output stage holds its byte while res_ready is low; the
//   packing stage then backs up and sym_ready drops, items that complete
//   no byte still pass.
// ----------------------------------------------------------------------------
module huffman_code_bit_packer import hcbp_pkg::*; #(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sym_valid,
	output logic              sym_ready,
	input  logic [1:0]        func,
	input  logic [7:0]        symbol,
	input  logic [31:0]       code_bits,
	input  logic [5:0]        code_len,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              last_of_run
);

	localparam int LEN_CAP = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
	localparam int AW      = $clog2(NUM_SYMBOLS);
	localparam int LW      = $clog2(LEN_CAP + 1);
	localparam int EW      = LW + LEN_CAP;
	localparam int ACC_W   = LEN_CAP + 2 * BYTE_W;
	localparam int TOT_W   = $clog2(LEN_CAP + BYTE_W);
	localparam int NB_W    = TOT_W - 3;

	logic               accept;
	logic               tbl_busy;
	logic               pack_ready;
	logic [AW+7:0]      sym_wide;
	logic [AW-1:0]      addr;
	logic               in_range;
	logic               is_load;
	logic               is_enc;
	logic               is_flush;
	logic [5:0]         len_sat;
	logic [LEN_CAP-1:0] bits_masked;
	logic [EW-1:0]      entry_wr;
	logic [EW-1:0]      entry_rd;
	logic               emit_free;
	logic               emit_load;
	logic [ACC_W-1:0]   emit_word;
	logic [NB_W-1:0]    emit_nb;

	// handshake
	assign sym_ready = !tbl_busy && pack_ready;
	assign accept    = sym_valid && sym_ready;

	// decode
	assign is_load  = (func == FUNC_LOAD);
	assign is_enc   = (func == FUNC_ENCODE);
	assign is_flush = (func == FUNC_FLUSH);
	assign sym_wide = (AW + 8)'(symbol);
	assign addr     = sym_wide[AW-1:0];
	assign in_range = (32'(symbol) < 32'(NUM_SYMBOLS));

	// saturate the length and drop code bits above it
	assign len_sat = (code_len > 6'(LEN_CAP)) ? 6'(LEN_CAP) : code_len;
	always_comb begin
		for (int i = 0; i < LEN_CAP; i++) begin
			bits_masked[i] = code_bits[i] && (6'(i) < len_sat);
		end
	end
	assign entry_wr = {LW'(len_sat), bits_masked};

	hcbp_table #(
		.NUM_SYMBOLS (NUM_SYMBOLS),
		.LEN_CAP     (LEN_CAP)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept && is_load && in_range),
		.wr_addr (addr),
		.wr_data (entry_wr),
		.rd_en   (accept && is_enc),
		.rd_addr (addr),
		.rd_data (entry_rd),
		.busy    (tbl_busy)
	);

	hcbp_pack #(
		.LEN_CAP (LEN_CAP)
	) u_pack (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (accept && (is_enc || is_flush)),
		.take_flush (is_flush),
		.take_enc   (is_enc),
		.take_inr   (in_range),
		.entry      (entry_rd),
		.ready      (pack_ready),
		.emit_free  (emit_free),
		.emit_load  (emit_load),
		.emit_word  (emit_word),
		.emit_nb    (emit_nb)
	);

	hcbp_emit #(
		.LEN_CAP (LEN_CAP)
	) u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (emit_load),
		.word        (emit_word),
		.nb          (emit_nb),
		.free        (emit_free),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	// a byte that is not the last of its item is followed by another
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !last_of_run |=> res_valid)
		else $error("byte run ended without last_of_run");

	// nothing is in flight while the table sweep runs
	a_sweep_idle: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_busy |-> !res_valid && !sym_ready)
		else $error("activity during table clearing");

	// a new run cannot start over a byte that waits mid-run
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |-> !res_valid || (res_ready && last_of_run))
		else $error("output stage overwritten before its run finished");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for huffman_code_bit_packer. Items are driven on the
// symbol channel while a scoreboard predicts the packed bytes; the checker
// compares each byte taken from the result channel with the oldest expected
// one. Directed corner cases run first, then a table load and random streams
// under varied sender idling and receiver stalls, then a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;
	import hcbp_pkg::*;

	localparam int LEN_CAP      = (MAX_CODE_LEN_DEF < CODE_FIELD_W) ?
	                              MAX_CODE_LEN_DEF : CODE_FIELD_W;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} packed_byte_t;

	logic        clk         = 1'b0;
	logic        arst_n      = 1'b0;
	logic        sym_valid   = 1'b0;
	logic        sym_ready;
	logic [1:0]  func        = FUNC_NONE;
	logic [7:0]  symbol      = 8'd0;
	logic [31:0] code_bits   = 32'd0;
	logic [5:0]  code_len    = 6'd0;
	logic        res_valid;
	logic        res_ready   = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic        last_of_run;

	// scoreboard copy of the packer state
	logic [31:0] tbl_bits [NUM_SYMBOLS_DEF];
	logic [5:0]  tbl_len  [NUM_SYMBOLS_DEF];
	logic [6:0]  pend_bits;
	int          pend_cnt;
	packed_byte_t expected_bytes[$];

	int errors       = 0;
	int cycle_cnt    = 0;
	int src_idle_pct = 0;
	int rcv_stall_pct = 0;
	logic hold_on    = 1'b0;
	event hold_ev;

	huffman_code_bit_packer u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.sym_valid   (sym_valid),
		.sym_ready   (sym_ready),
		.func        (func),
		.symbol      (symbol),
		.code_bits   (code_bits),
		.code_len    (code_len),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (hold_on)
			res_ready <= 1'b0;
		else
			res_ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	// long hold-off, counted on the falling edge
	always begin
		@(hold_ev);
		@(negedge clk);
		hold_on = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		hold_on = 1'b0;
	end

	// compare each accepted byte against the oldest expectation
	always @(posedge clk) begin
		packed_byte_t want;
		if (arst_n && res_valid && res_ready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte %02h last %0b", $time, out_byte, last_of_run);
				errors++;
			end else begin
				want = expected_bytes.pop_front();
				if (want.data !== out_byte) begin
					$display("%0t: out_byte expected %02h actual %02h",
					         $time, want.data, out_byte);
					errors++;
				end
				if (want.last !== last_of_run) begin
					$display("%0t: last_of_run expected %0b actual %0b",
					         $time, want.last, last_of_run);
					errors++;
				end
			end
		end
	end

	// predict the bytes an item produces and update the scoreboard state
	task automatic pack_expected(input func_t f, input logic [7:0] s,
	                             input logic [31:0] b, input logic [5:0] l);
		int           n;
		int           total;
		int           nbytes;
		logic [63:0]  acc;
		logic [63:0]  shifted;
		packed_byte_t r;
		case (f)
			FUNC_LOAD: begin
				n = (l > LEN_CAP) ? LEN_CAP : l;
				tbl_len[s]  = 6'(n);
				tbl_bits[s] = 32'({32'd0, b} & ((64'd1 << n) - 64'd1));
			end
			FUNC_ENCODE: begin
				n = tbl_len[s];
				if (n != 0) begin
					acc    = ({57'd0, pend_bits} << n) | {32'd0, tbl_bits[s]};
					total  = pend_cnt + n;
					nbytes = total / BYTE_W;
					for (int k = 0; k < nbytes; k++) begin
						total  -= BYTE_W;
						shifted = acc >> total;
						r.data  = shifted[7:0];
						r.last  = (k == nbytes - 1);
						expected_bytes.push_back(r);
					end
					shifted   = acc & ((64'd1 << total) - 64'd1);
					pend_bits = shifted[6:0];
					pend_cnt  = total;
				end
			end
			FUNC_FLUSH: begin
				if (pend_cnt != 0) begin
					shifted = {57'd0, pend_bits} << (BYTE_W - pend_cnt);
					r.data  = shifted[7:0];
					r.last  = 1'b1;
					expected_bytes.push_back(r);
					pend_bits = '0;
					pend_cnt  = 0;
				end
			end
			default: ;
		endcase
	endtask

	// offer one item after a random gap, wait for acceptance, predict
	task automatic send_item(input func_t f, input logic [7:0] s,
	                         input logic [31:0] b, input logic [5:0] l);
		while ($urandom_range(99) < src_idle_pct) begin
			sym_valid <= 1'b0;
			@(posedge clk);
		end
		sym_valid <= 1'b1;
		func      <= f;
		symbol    <= s;
		code_bits <= b;
		code_len  <= l;
		do @(posedge clk); while (!sym_ready);
		pack_expected(f, s, b, l);
	endtask

	// idling mix for the next phase, changed away from the sampling edge
	task automatic set_idling(input int idle, input int stall);
		@(negedge clk);
		src_idle_pct  = idle;
		rcv_stall_pct = stall;
		@(posedge clk);
	endtask

	// drop valid and let every expected byte come out
	task automatic drain;
		sym_valid <= 1'b0;
		@(posedge clk);
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [5:0] random_len();
		int r;
		r = $urandom_range(99);
		if (r < 5)  return 6'd0;
		if (r < 15) return 6'($urandom_range(63, 33));
		if (r < 30) return 6'($urandom_range(32, 13));
		return 6'($urandom_range(12, 1));
	endfunction

	// corner cases: empty table, overlong and excess bits, full codes, flushes
	task automatic test_directed;
		set_idling(0, 0);
		send_item(FUNC_ENCODE, 8'd0, 32'd0, 6'd0);           // unloaded symbol
		send_item(FUNC_FLUSH, 8'd0, 32'd0, 6'd0);            // flush with nothing pending
		send_item(FUNC_NONE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);   // unknown func
		send_item(FUNC_LOAD, 8'd255, 32'hFFFF_FFFF, 6'd63);  // overlong length
		send_item(FUNC_ENCODE, 8'd255, 32'd0, 6'd0);         // four full bytes
		send_item(FUNC_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd0);     // empty code
		send_item(FUNC_ENCODE, 8'd0, 32'hFFFF_FFFF, 6'h3F);
		send_item(FUNC_LOAD, 8'd1, 32'hFFFF_FFF5, 6'd3);     // excess bits dropped
		send_item(FUNC_ENCODE, 8'd1, 32'd0, 6'd0);
		send_item(FUNC_ENCODE, 8'd1, 32'd0, 6'd0);
		send_item(FUNC_ENCODE, 8'd1, 32'd0, 6'd0);
		send_item(FUNC_FLUSH, 8'd0, 32'd0, 6'd0);
		send_item(FUNC_LOAD, 8'd2, 32'hA5A5_5A5A, 6'd32);
		send_item(FUNC_ENCODE, 8'd1, 32'd0, 6'd0);
		send_item(FUNC_ENCODE, 8'd2, 32'd0, 6'd0);
		send_item(FUNC_FLUSH, 8'd0, 32'd0, 6'd0);
		send_item(FUNC_LOAD, 8'd3, 32'h0000_0001, 6'd33);
		send_item(FUNC_ENCODE, 8'd3, 32'd0, 6'd0);
		send_item(FUNC_LOAD, 8'd128, 32'hFFFF_FF2A, 6'd7);
		send_item(FUNC_ENCODE, 8'd128, 32'd0, 6'd0);         // seven pending
		send_item(FUNC_ENCODE, 8'd255, 32'd0, 6'd0);         // 39 bits, four bytes
		send_item(FUNC_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
		drain();
	endtask

	// working set of short codes for the random streams
	task automatic test_table_load;
		set_idling(0, 0);
		for (int i = 0; i < 16; i++)
			send_item(FUNC_LOAD, 8'(i), $urandom, 6'($urandom_range(12, 1)));
		drain();
	endtask

	// mostly encodes of loaded symbols, some reloads, flushes and noise
	task automatic test_random_stream(input int count, input int idle, input int stall);
		int          r;
		logic [7:0]  s;
		set_idling(idle, stall);
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			s = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(15));
			if (r < 12)
				send_item(FUNC_LOAD, s, $urandom, random_len());
			else if (r < 80)
				send_item(FUNC_ENCODE, s, $urandom, 6'($urandom_range(63)));
			else if (r < 92)
				send_item(FUNC_FLUSH, 8'($urandom_range(255)), $urandom,
				          6'($urandom_range(63)));
			else if (r < 96)
				send_item(FUNC_NONE, 8'($urandom_range(255)), $urandom,
				          6'($urandom_range(63)));
			else
				send_item(func_t'($urandom_range(3)), 8'($urandom_range(255)), $urandom,
				          6'($urandom_range(63)));
		end
		drain();
	endtask

	// receiver holds off while full-length codes keep coming
	task automatic test_backpressure;
		set_idling(0, 0);
		send_item(FUNC_LOAD, 8'd254, $urandom, 6'd32);
		-> hold_ev;
		for (int i = 0; i < 40; i++)
			send_item(FUNC_ENCODE, 8'd254, 32'd0, 6'd0);
		send_item(FUNC_FLUSH, 8'd0, 32'd0, 6'd0);
		drain();
	endtask

	initial begin
		pend_bits = '0;
		pend_cnt  = 0;
		for (int i = 0; i < NUM_SYMBOLS_DEF; i++) begin
			tbl_bits[i] = '0;
			tbl_len[i]  = '0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_table_load();
		test_random_stream(20, 0, 0);
		test_random_stream(20, 77, 0);
		test_random_stream(20, 0, 77);
		test_random_stream(20, 23, 23);
		test_backpressure();

		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
